// ----- rtl/uvll_pkg.sv -----
// ----------------------------------------------------------------------------
// Unique-value linked list package
// Shared types and constants for the linked list unit and its memories.
// ----------------------------------------------------------------------------
package uvll_pkg;

   localparam int unsigned CapacityDefault = 64;
   localparam int unsigned LinkWidth = 7;
   localparam logic [LinkWidth-1:0] NullLink = 7'd127;

   typedef enum logic [2:0] {
      ACT_APPEND  = 3'd0,
      ACT_PREPEND = 3'd1,
      ACT_BEFORE  = 3'd2,
      ACT_AFTER   = 3'd3,
      ACT_REMOVE  = 3'd4,
      ACT_REVERSE = 3'd5,
      ACT_DUMP    = 3'd6,
      ACT_NONE    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
      logic signed [31:0] anchor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] item_value;
      logic [2:0]         status;
      logic               last;
      logic [6:0]         list_size;
   } rsp_type;

   // One pool node as held in the node memory.
   typedef struct packed {
      logic [31:0]          value;
      logic [LinkWidth-1:0] next;
      logic [LinkWidth-1:0] prev;
   } node_type;

endpackage

// ----- rtl/uvll_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module uvll_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/uvll_free_pool.sv -----
// ----------------------------------------------------------------------------
// Free node pool
// Free bitmap with a registered lowest-free index, so a take never waits.
// ----------------------------------------------------------------------------
module uvll_free_pool #(
   parameter int unsigned Capacity = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic                        give,
   input  logic [$clog2(Capacity)-1:0] give_idx,
   output logic                        any_free,
   output logic [$clog2(Capacity)-1:0] free_idx
);
   import uvll_pkg::*;
   localparam int unsigned IdxW = $clog2(Capacity);

   logic [Capacity-1:0] map_ff, map_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic                any_ff, any_in;

   always_comb begin
      map_in = map_ff;
      if (take) begin
         map_in[idx_ff] = 1'b0;
      end
      if (give) begin
         map_in[give_idx] = 1'b1;
      end
      idx_in = '0;
      any_in = 1'b0;
      for (int i = Capacity - 1; i >= 0; i--) begin
         if (map_in[i]) begin
            idx_in = IdxW'(i);
            any_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '1;
         idx_ff <= '0;
         any_ff <= 1'b1;
      end else begin
         map_ff <= map_in;
         idx_ff <= idx_in;
         any_ff <= any_in;
      end
   end

   assign any_free = any_ff;
   assign free_idx = idx_ff;
endmodule

// ----- rtl/unique_value_linked_list_unit.sv -----
// ----------------------------------------------------------------------------
// Unique-value linked list unit
// Ordered list of distinct values in a node pool held in one memory.
// ----------------------------------------------------------------------------
//  channel   ports                        beat
//  request   start, busy, req_data        start high while busy low
//  response  rsp_valid, rsp_data          one cycle per rsp_valid pulse
//
//  Each list walk reads one node at a time through the node memory port. A dump
//  gives one beat per element; every final beat comes in the same cycle that
//  busy falls. Reset is synchronous and clears the list control state; the node
//  memory is not cleared. Results cannot stall.
// ----------------------------------------------------------------------------
module unique_value_linked_list_unit #(
   parameter int unsigned Capacity = uvll_pkg::CapacityDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  uvll_pkg::req_type req_data,
   output logic              rsp_valid,
   output uvll_pkg::rsp_type rsp_data
);
   import uvll_pkg::*;
   localparam int unsigned IdxW = $clog2(Capacity);
   localparam int unsigned NodeW = 32 + 2 * LinkWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND_RD, S_FIND_CHK, S_ANCH_RD, S_ANCH_CHK, S_NBR_RD, S_NBR_WAIT,
      S_LINK, S_NBR2, S_DUMP_RD, S_DUMP_CHK, S_RESP
   } state_type;

   state_type            state_ff;
   req_type              req_ff;
   logic [LinkWidth-1:0] head_ff, tail_ff, ptr_ff, found_ff, anchor_ff, node_ff;
   logic [6:0]           count_ff, steps_ff;
   logic                 rev_ff, phase_ff;
   logic [2:0]           status_ff;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [31:0]          rsp_item_ff;
   node_type             cur_ff;
   logic                 give_pending_ff;

   logic                 mem_we;
   logic [IdxW-1:0]      mem_addr;
   node_type             mem_wdata, mem_rdata, nbr_fix;
   logic                 pool_take, pool_give, pool_any;
   logic [IdxW-1:0]      pool_idx, give_idx_ff;

   uvll_ram #(.Width(NodeW), .Depth(Capacity)) u_nodes (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wdata), .rd_data(mem_rdata)
   );

   uvll_free_pool #(.Capacity(Capacity)) u_pool (
      .clock(clock), .reset(reset), .take(pool_take), .give(pool_give),
      .give_idx(give_idx_ff), .any_free(pool_any), .free_idx(pool_idx)
   );

   logic is_insert, phys_after, pos_after;
   logic [LinkWidth-1:0] lnk_a, lnk_b, newn;
   assign is_insert = req_ff.action inside {ACT_APPEND, ACT_PREPEND, ACT_BEFORE, ACT_AFTER};
   assign pos_after = (req_ff.action == ACT_APPEND) || (req_ff.action == ACT_AFTER);
   assign phys_after = pos_after ^ rev_ff;
   assign newn = LinkWidth'(pool_idx);

   // Memory port control: one access a cycle.
   always_comb begin
      mem_we = 1'b0;
      mem_addr = ptr_ff[IdxW-1:0];
      mem_wdata = cur_ff;
      lnk_a = NullLink;
      lnk_b = NullLink;
      if (req_ff.action inside {ACT_BEFORE, ACT_AFTER}) begin
         lnk_a = phys_after ? anchor_ff : cur_ff.prev;
         lnk_b = phys_after ? cur_ff.next : anchor_ff;
      end else if (phys_after) begin
         lnk_a = tail_ff;
      end else begin
         lnk_b = head_ff;
      end
      case (state_ff)
         S_LINK: begin
            if (is_insert) begin
               mem_we = 1'b1;
               mem_addr = pool_idx;
               mem_wdata = '{value: req_ff.value, next: lnk_b, prev: lnk_a};
            end
         end
         S_NBR2: begin
            mem_we = 1'b1;
         end
         default: ;
      endcase
   end

   // Phase zero fixes the previous neighbor's next link, phase one the next
   // neighbor's previous link.
   always_comb begin
      nbr_fix = mem_rdata;
      if (!phase_ff) begin
         nbr_fix.next = node_ff;
      end else if (is_insert) begin
         nbr_fix.prev = node_ff;
      end else begin
         nbr_fix.prev = anchor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= NullLink;
         tail_ff <= NullLink;
         count_ff <= '0;
         rev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_RESP) || (state_ff == S_DUMP_CHK);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  steps_ff <= '0;
                  found_ff <= NullLink;
                  ptr_ff <= (req_data.action == ACT_DUMP && rev_ff) ? tail_ff : head_ff;
                  status_ff <= (count_ff == '0 &&
                                req_data.action inside {ACT_REMOVE, ACT_REVERSE, ACT_DUMP})
                               ? ST_EMPTY : ST_DONE;
                  case (req_data.action)
                     ACT_APPEND, ACT_PREPEND, ACT_BEFORE, ACT_AFTER: begin
                        state_ff <= (head_ff == NullLink) ? S_ANCH_RD : S_FIND_RD;
                     end
                     ACT_REMOVE: begin
                        state_ff <= (count_ff == '0) ? S_RESP : S_FIND_RD;
                     end
                     ACT_REVERSE: begin
                        if (count_ff != '0) begin
                           rev_ff <= ~rev_ff;
                        end
                        state_ff <= S_RESP;
                     end
                     ACT_DUMP: begin
                        state_ff <= (count_ff == '0) ? S_RESP : S_DUMP_RD;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            S_FIND_RD: state_ff <= S_FIND_CHK;
            S_FIND_CHK: begin
               if (mem_rdata.value == req_ff.value) begin
                  found_ff <= ptr_ff;
                  cur_ff <= mem_rdata;
                  if (req_ff.action == ACT_REMOVE) begin
                     state_ff <= S_LINK;
                  end else begin
                     status_ff <= ST_DUPLICATE;
                     state_ff <= S_RESP;
                  end
               end else if (mem_rdata.next == NullLink || steps_ff + 7'd1 >= 7'(Capacity)) begin
                  if (req_ff.action == ACT_REMOVE) begin
                     status_ff <= ST_NOT_FOUND;
                     state_ff <= S_RESP;
                  end else begin
                     ptr_ff <= head_ff;
                     steps_ff <= '0;
                     state_ff <= S_ANCH_RD;
                  end
               end else begin
                  steps_ff <= steps_ff + 7'd1;
                  ptr_ff <= mem_rdata.next;
                  state_ff <= S_FIND_RD;
               end
            end
            S_ANCH_RD: begin
               if (req_ff.action inside {ACT_BEFORE, ACT_AFTER}) begin
                  if (count_ff == '0) begin
                     status_ff <= ST_EMPTY;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_ANCH_CHK;
                  end
               end else if (!pool_any) begin
                  status_ff <= ST_FULL;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_LINK;
               end
            end
            S_ANCH_CHK: begin
               steps_ff <= steps_ff + 7'd1;
               if (mem_rdata.value == req_ff.anchor) begin
                  anchor_ff <= ptr_ff;
                  cur_ff <= mem_rdata;
                  if (!pool_any) begin
                     status_ff <= ST_FULL;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_LINK;
                  end
               end else if (mem_rdata.next == NullLink || steps_ff + 7'd1 >= 7'(Capacity)) begin
                  status_ff <= ST_NOT_FOUND;
                  state_ff <= S_RESP;
               end else begin
                  ptr_ff <= mem_rdata.next;
                  state_ff <= S_ANCH_RD;
               end
            end
            S_LINK: begin
               if (is_insert) begin
                  node_ff <= newn;
                  found_ff <= lnk_b;
                  anchor_ff <= lnk_a;
                  count_ff <= count_ff + 7'd1;
                  if (lnk_a == NullLink) begin
                     head_ff <= newn;
                  end
                  if (lnk_b == NullLink) begin
                     tail_ff <= newn;
                  end
                  ptr_ff <= (lnk_a == NullLink) ? lnk_b : lnk_a;
                  phase_ff <= (lnk_a == NullLink);
                  state_ff <= (lnk_a == NullLink && lnk_b == NullLink) ? S_RESP : S_NBR_RD;
               end else begin
                  node_ff <= cur_ff.next;
                  found_ff <= cur_ff.next;
                  anchor_ff <= cur_ff.prev;
                  count_ff <= count_ff - 7'd1;
                  if (cur_ff.prev == NullLink) begin
                     head_ff <= cur_ff.next;
                  end
                  if (cur_ff.next == NullLink) begin
                     tail_ff <= cur_ff.prev;
                  end
                  ptr_ff <= (cur_ff.prev == NullLink) ? cur_ff.next : cur_ff.prev;
                  phase_ff <= (cur_ff.prev == NullLink);
                  state_ff <= (cur_ff.prev == NullLink && cur_ff.next == NullLink)
                              ? S_RESP : S_NBR_RD;
               end
            end
            S_NBR_RD: state_ff <= S_NBR_WAIT;
            S_NBR_WAIT: begin
               cur_ff <= nbr_fix;
               state_ff <= S_NBR2;
            end
            S_NBR2: begin
               if (!phase_ff && found_ff != NullLink) begin
                  phase_ff <= 1'b1;
                  ptr_ff <= found_ff;
                  state_ff <= S_NBR_RD;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_DUMP_RD: state_ff <= S_DUMP_CHK;
            S_DUMP_CHK: begin
               steps_ff <= steps_ff + 7'd1;
               rsp_item_ff <= mem_rdata.value;
               ptr_ff <= rev_ff ? mem_rdata.prev : mem_rdata.next;
               if (steps_ff + 7'd1 >= count_ff) begin
                  rsp_last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rsp_last_ff <= 1'b0;
                  state_ff <= S_DUMP_RD;
               end
            end
            S_RESP: begin
               rsp_item_ff <= '0;
               rsp_last_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LINK && !is_insert) begin
         give_idx_ff <= found_ff[IdxW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         give_pending_ff <= 1'b0;
      end else begin
         give_pending_ff <= (state_ff == S_LINK) && !is_insert;
      end
   end

   assign pool_take = (state_ff == S_LINK) && is_insert;
   assign pool_give = give_pending_ff;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = '{item_value: rsp_item_ff, status: status_ff,
                       last: rsp_last_ff, list_size: count_ff};

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("start beat not taken");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(Capacity))
      else $error("element count above capacity");
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == NullLink && tail_ff == NullLink))
      else $error("empty list with linked head");
endmodule
